// File: hw/rtl/aes128_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box, round constants and round helpers.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned NumRnd = 10;

  localparam logic KEY_HIGH_IDX = 1'b0;
  localparam logic KEY_LOW_IDX  = 1'b1;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic [HalfW-1:0] plain_high;
    logic [HalfW-1:0] plain_low;
  } in_word_t;

  typedef struct packed {
    logic [HalfW-1:0] cipher_high;
    logic [HalfW-1:0] cipher_low;
  } out_word_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRnd] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // byte n of the block at bits 127-8n
  function automatic logic [7:0] get_b(blk_t v, int unsigned n);
    return v[127-8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t next_key(blk_t rk, logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[get_b(rk, 13)] ^ rc, SBOX[get_b(rk, 14)],
          SBOX[get_b(rk, 15)], SBOX[get_b(rk, 12)]};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic blk_t enc_round(blk_t s, blk_t rk, logic mix);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = SBOX[get_b(s, 4*((c+r)%4)+r)];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_b(t, 4*c);
        a1 = get_b(t, 4*c+1);
        a2 = get_b(t, 4*c+2);
        a3 = get_b(t, 4*c+3);
        al = a0 ^ a1 ^ a2 ^ a3;
        t[127-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
        t[127-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
        t[127-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
        t[127-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    return t ^ rk;
  endfunction

endpackage

// File: hw/rtl/aes128_if.sv
// ----------------------------------------------------------------------------
// AES-128 stream interfaces
// Valid/ready channels for plaintext and ciphertext words.
// ----------------------------------------------------------------------------
interface aes128_in_if;
  logic                 valid;
  logic                 ready;
  aes128_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aes128_out_if;
  logic                  valid;
  logic                  ready;
  aes128_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt top
// Fully unrolled AES-128 encryption pipeline with precomputed round keys.
// ----------------------------------------------------------------------------
// Takes one 128-bit plaintext word per cycle unless the output stalls.
// There are eleven register stages: an input stage that adds the cipher
// key, then one stage per round. Each word passes through them in turn.
// The round keys come from a ten-stage chain fed by the key registers.
// That chain runs one stage ahead of the data, so a word may follow a key
// write in the very next cycle. Write the key only while no word is in
// flight. A stall freezes the data stages and nothing is lost.
module aes128_block_encrypt_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [aes128_pkg::KeyW-1:0] cfg_data_i,
  aes128_in_if.sink                in_if,
  aes128_out_if.source             out_if
);
  import aes128_pkg::*;

  logic [KeyW-1:0] key_hi_q, key_lo_q;
  blk_t            rk_q   [1:NumRnd];
  blk_t            st_q   [NumRnd+1];
  logic            vld_q  [NumRnd+1];
  logic            adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        KEY_HIGH_IDX: key_hi_q <= cfg_data_i;
        KEY_LOW_IDX:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q[1] <= next_key({key_hi_q, key_lo_q}, RCON[0]);
    for (int i = 2; i <= NumRnd; i++) begin
      rk_q[i] <= next_key(rk_q[i-1], RCON[i-1]);
    end
  end

  assign adv          = !vld_q[NumRnd] || out_if.ready;
  assign in_if.ready  = adv;
  assign out_if.valid = vld_q[NumRnd];
  assign out_if.data  = {st_q[NumRnd][127:64], st_q[NumRnd][63:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NumRnd; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_if.valid;
      for (int i = 1; i <= NumRnd; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= {in_if.data.plain_high, in_if.data.plain_low} ^ {key_hi_q, key_lo_q};
      for (int i = 1; i <= NumRnd; i++) begin
        st_q[i] <= enc_round(st_q[i-1], rk_q[i], i != NumRnd);
      end
    end
  end

endmodule

// File: sim/tb_aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Drives plaintext words under several keys, predicts each ciphertext with
// an independent cipher model and checks results in order with random stalls.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aes128_pkg::*;

  localparam int unsigned MaxCycles = 400000;
  localparam int unsigned Latency   = 11;

  // independent AES-128 model
  class cipher_scoreboard;
    logic [7:0] sb [256];
    logic [63:0] key_hi, key_lo;
    out_word_t pending [$];
    int unsigned n_err, n_checked;

    function new();
      logic [7:0] p, q, x;
      // build S-box from GF(2^8) inverse and affine map
      p = 8'h01;
      q = 8'h01;
      do begin
        p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
        q = q ^ {q[6:0], 1'b0};
        q = q ^ {q[5:0], 2'b00};
        q = q ^ {q[3:0], 4'b0000};
        if (q[7]) q = q ^ 8'h09;
        x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^
            {q[3:0], q[7:4]};
        sb[p] = x ^ 8'h63;
      end while (p != 8'h01);
      sb[0] = 8'h63;
      key_hi = '0;
      key_lo = '0;
      n_err = 0;
      n_checked = 0;
    endfunction

    function automatic logic [7:0] dbl(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] encrypt(logic [127:0] pt);
      logic [7:0] st [16], rk [16], tmp [16], tw [4], rc, a0, a1, a2, a3, al;
      logic [127:0] kk;
      kk = {key_hi, key_lo};
      for (int i = 0; i < 16; i++) begin
        rk[i] = kk[127-8*i -: 8];
        st[i] = pt[127-8*i -: 8] ^ rk[i];
      end
      rc = 8'h01;
      for (int rnd = 1; rnd <= 10; rnd++) begin
        tw[0] = sb[rk[13]] ^ rc;
        tw[1] = sb[rk[14]];
        tw[2] = sb[rk[15]];
        tw[3] = sb[rk[12]];
        for (int i = 0; i < 16; i++) begin
          rk[i] = rk[i] ^ tw[i % 4];
          tw[i % 4] = rk[i];
        end
        rc = dbl(rc);
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[4*c+r] = sb[st[4*((c+r)%4)+r]];
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            tmp[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            tmp[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            tmp[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            tmp[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) encrypt[127-8*i -: 8] = st[i];
    endfunction

    function void note_plain(in_word_t w);
      logic [127:0] ct;
      out_word_t e;
      ct = encrypt({w.plain_high, w.plain_low});
      e.cipher_high = ct[127:64];
      e.cipher_low  = ct[63:0];
      pending.push_back(e);
    endfunction

    task check_cipher(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        report_err("unexpected ciphertext word", got.cipher_high, '0);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (got.cipher_high !== e.cipher_high)
        report_err("cipher_high", got.cipher_high, e.cipher_high);
      if (got.cipher_low !== e.cipher_low)
        report_err("cipher_low", got.cipher_low, e.cipher_low);
    endtask

    task report_err(string what, logic [63:0] got, logic [63:0] exp_v);
      n_err++;
      $display("MISMATCH %s: got %h expected %h", what, got, exp_v);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = KEY_HIGH_IDX;
  logic [KeyW-1:0] cfg_data_i = '0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 13;
  bit sent_done = 1'b0;

  aes128_in_if  in_if ();
  aes128_out_if out_if ();

  cipher_scoreboard cipher_sb = new();

  aes128_block_encrypt_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: sample both handshakes, then randomize ready
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) cipher_sb.check_cipher(out_if.data);
    if (rst_ni && in_if.valid && in_if.ready) cipher_sb.note_plain(in_if.data);
    out_if.ready <= rst_ni && ($urandom_range(99) >= idle_pct);
  end

  task automatic write_key(logic [63:0] hi, logic [63:0] lo);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= KEY_HIGH_IDX;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_idx_i  <= KEY_LOW_IDX;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cipher_sb.key_hi = hi;
    cipher_sb.key_lo = lo;
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic send_plain(logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{plain_high: hi, plain_low: lo};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
    while (cipher_sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_burst(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: send_plain('0, rnd64());
        1: send_plain(rnd64(), '1);
        2: send_plain(64'h1 << $urandom_range(63), 64'h1 << $urandom_range(63));
        default: send_plain(rnd64(), rnd64());
      endcase
    end
    end_burst();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (Latency + 2) @(posedge clk_i);

    // reset key is all zeros
    send_plain('0, '0);
    send_plain('1, '1);
    send_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
    end_burst();

    // FIPS-197 appendix key, then extremes
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_plain('0, '1);
    send_plain(64'h8000000000000000, 64'h1);
    end_burst();
    write_key('1, '1);
    send_plain('0, '0);
    send_plain('1, '1);
    send_plain(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    end_burst();
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_plain(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    end_burst();

    // no-idle stretch
    idle_pct = 0;
    write_key(rnd64(), rnd64());
    random_burst(80);
    idle_pct = 13;

    for (int k = 0; k < 6; k++) begin
      if (k == 3) write_key('0, '1);
      else write_key(rnd64(), rnd64());
      random_burst(60);
    end

    $display("Covered %0d ciphertext words under 11 keys, zero/ones keys included",
             cipher_sb.n_checked);
    if (cipher_sb.n_err == 0 && cipher_sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
